// ----- design/railcom_detector_frame_decoder_assert.svh -----
// Assertion helpers for the detector frame decoder checker.
// Both sample on i_clk and are disabled while i_rst_n is low.
`ifndef RAILCOM_DETECTOR_FRAME_DECODER_ASSERT_SVH
`define RAILCOM_DETECTOR_FRAME_DECODER_ASSERT_SVH

// Same-cycle implication
`define RCD_ASSERT_IMPLY(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define RCD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/rcd_pkg.sv -----
package rcd_pkg;

    // Number of detectors with an address table entry (entry 0 unused)
    localparam int DETECTORS = 24;
    localparam int DET_W     = $clog2(DETECTORS + 1);
    localparam int TBL_DEPTH = DETECTORS + 1;

    // Frame start bytes and markers
    localparam logic [7:0] START_DIAG = 8'hD1;
    localparam logic [7:0] START_OFF  = 8'hFA;
    localparam logic [7:0] START_ADDR = 8'hFC;
    localparam logic [7:0] START_SYS  = 8'hFD;
    localparam logic [7:0] START_CV   = 8'hFE;
    localparam logic [7:0] END_BYTE   = 8'hFF;
    localparam logic [7:0] BARE_OCC   = 8'h77;
    localparam logic [7:0] CMD_REINIT = 8'h20;
    localparam logic [3:0] MAX_BYTES  = 4'd11;

    // Report kinds on the output tuser
    typedef enum logic [1:0] {
        KIND_ADDR = 2'd0,
        KIND_CV   = 2'd1,
        KIND_SYS  = 2'd2
    } t_kind;

    // Closed frame handed to the evaluation stage
    typedef struct packed {
        t_kind      kind;
        logic [7:0] det;
        logic [7:0] a1;
        logic [7:0] a2;
    } t_frame;

    // One report
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  det;
        logic [14:0] loco;
        logic        fwd;
        logic        occ;
        logic [7:0]  cv;
        logic [7:0]  cmd;
    } t_result;

    // {hit, data length} for a byte seen outside a frame
    function automatic logic [4:0] start_len(input logic [7:0] b);
        logic [4:0] r;
        unique case (b)
            START_DIAG: r = {1'b1, 4'd10};
            START_OFF:  r = {1'b1, 4'd0};
            START_ADDR: r = {1'b1, 4'd3};
            START_SYS:  r = {1'b1, 4'd4};
            START_CV:   r = {1'b1, 4'd2};
            default:    r = 5'd0;
        endcase
        return r;
    endfunction

    function automatic logic det_in_range(input logic [7:0] det);
        return (det != 8'd0) && (det <= 8'(DETECTORS));
    endfunction

endpackage

// ----- design/rcd_ram.sv -----
// Single-port-write, single-port-read RAM with registered read data
module rcd_ram #(
    parameter int WIDTH = 15,
    parameter int DEPTH = 25,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ----- design/rcd_parser.sv -----
// Byte-level framer: tracks frame length and keeps header bytes
module rcd_parser (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_accept,
    input  logic [7:0]     i_byte,
    output logic           o_evt_valid,
    output rcd_pkg::t_frame o_evt
);

    logic       r_in_frame, n_in_frame;
    logic [3:0] r_exp_len, n_exp_len;
    logic [3:0] r_cnt, n_cnt;
    logic [7:0] r_kind, r_det, r_a1, r_a2;

    logic [4:0] start;
    logic [3:0] cnt_m1;
    logic       close;
    logic       store;

    always_comb begin
        start  = rcd_pkg::start_len(i_byte);
        cnt_m1 = r_cnt - 4'd1;
        close  = r_in_frame && (cnt_m1 == r_exp_len) && (i_byte == rcd_pkg::END_BYTE);
        store  = r_in_frame && !close && (cnt_m1 < r_exp_len) && (r_cnt < rcd_pkg::MAX_BYTES);
    end

    // Frame control
    always_comb begin
        n_in_frame = r_in_frame;
        n_exp_len  = r_exp_len;
        n_cnt      = r_cnt;
        if (i_accept) begin
            if (!r_in_frame) begin
                if (start[4]) begin
                    n_in_frame = 1'b1;
                    n_exp_len  = start[3:0];
                    n_cnt      = 4'd1;
                end
            end else if (close) begin
                n_in_frame = 1'b0;
                n_exp_len  = 4'd0;
                n_cnt      = 4'd0;
            end else if (store) begin
                n_cnt = r_cnt + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_exp_len  <= 4'd0;
            r_cnt      <= 4'd0;
        end else begin
            r_in_frame <= n_in_frame;
            r_exp_len  <= n_exp_len;
            r_cnt      <= n_cnt;
        end
    end

    // Header bytes; later data bytes are never looked at
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            if (!r_in_frame && start[4]) begin
                r_kind <= i_byte;
            end
            if (store && r_cnt == 4'd1) begin
                r_det <= i_byte;
            end
            if (store && r_cnt == 4'd2) begin
                r_a1 <= i_byte;
            end
            if (store && r_cnt == 4'd3) begin
                r_a2 <= i_byte;
            end
        end
    end

    // Closing byte of a frame that reports something
    always_comb begin
        o_evt       = '0;
        o_evt_valid = 1'b0;
        o_evt.det   = r_det;
        o_evt.a1    = r_a1;
        o_evt.a2    = r_a2;
        priority case (r_kind)
            rcd_pkg::START_ADDR: begin
                o_evt.kind  = rcd_pkg::KIND_ADDR;
                o_evt_valid = i_accept && close;
            end
            rcd_pkg::START_CV: begin
                o_evt.kind  = rcd_pkg::KIND_CV;
                o_evt_valid = i_accept && close;
            end
            rcd_pkg::START_SYS: begin
                o_evt.kind  = rcd_pkg::KIND_SYS;
                o_evt_valid = i_accept && close;
            end
            default: begin
                o_evt.kind  = rcd_pkg::KIND_ADDR;
                o_evt_valid = 1'b0;
            end
        endcase
    end

endmodule

// ----- design/rcd_eval.sv -----
// Evaluation stage: table read-modify-write and output register
module rcd_eval (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_evt_valid,
    input  rcd_pkg::t_frame               i_evt,
    input  logic [14:0]                   i_rd_data,
    output logic                          o_ready,
    output logic                          o_we,
    output logic [rcd_pkg::DET_W-1:0]     o_waddr,
    output logic [14:0]                   o_wdata,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output rcd_pkg::t_result              o_result
);

    logic                         r_s1_valid;
    rcd_pkg::t_frame              r_s1;
    logic [rcd_pkg::TBL_DEPTH-1:0] r_vld;
    logic                         r_out_valid;
    rcd_pkg::t_result             r_out;

    logic                         adv;
    logic                         fire;
    logic [rcd_pkg::DET_W-1:0]    idx;
    logic [14:0]                  entry;
    logic [14:0]                  addr;
    logic                         fwd, occ, bare, det_ok;
    logic                         has;
    logic                         wr_req;
    rcd_pkg::t_result             res;

    assign adv     = !r_out_valid || i_out_ready;
    assign fire    = r_s1_valid && adv;
    assign o_ready = !r_s1_valid || adv;
    assign idx     = r_s1.det[rcd_pkg::DET_W-1:0];

    // Decode the frame held in stage one
    always_comb begin
        entry  = r_vld[idx] ? i_rd_data : 15'd0;
        addr   = {r_s1.a1[6:0], r_s1.a2};
        fwd    = !r_s1.a1[7];
        occ    = (addr != 15'd0);
        bare   = (r_s1.a1 == rcd_pkg::BARE_OCC) && (r_s1.a2 == rcd_pkg::BARE_OCC);
        det_ok = rcd_pkg::det_in_range(r_s1.det);
        has    = 1'b0;
        wr_req = 1'b0;
        res    = '0;
        o_wdata = 15'd0;
        unique case (r_s1.kind)
            rcd_pkg::KIND_ADDR: begin
                res.kind = rcd_pkg::KIND_ADDR;
                res.det  = r_s1.det;
                res.fwd  = fwd;
                if (bare) begin
                    addr = 15'd0;
                    occ  = 1'b1;
                end
                res.occ = occ;
                if (!det_ok) begin
                    has = 1'b0;
                end else if (bare) begin
                    // occupancy without address: report only an empty entry
                    has      = (entry == 15'd0);
                    res.loco = 15'd0;
                end else if (!occ) begin
                    // section freed
                    has      = 1'b1;
                    wr_req   = 1'b1;
                    res.loco = 15'd0;
                end else begin
                    // new address; repeats are suppressed
                    has      = (entry != addr);
                    wr_req   = (entry != addr);
                    o_wdata  = addr;
                    res.loco = addr;
                end
            end
            rcd_pkg::KIND_CV: begin
                has      = 1'b1;
                res.kind = rcd_pkg::KIND_CV;
                res.det  = r_s1.det;
                res.cv   = r_s1.a1;
            end
            rcd_pkg::KIND_SYS: begin
                has      = 1'b1;
                res.kind = rcd_pkg::KIND_SYS;
                res.cmd  = rcd_pkg::CMD_REINIT;
            end
            default: begin
                has = 1'b0;
            end
        endcase
    end

    assign o_we    = fire && wr_req;
    assign o_waddr = idx;

    // Stage one and entry valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_vld      <= '0;
        end else begin
            if (o_ready) begin
                r_s1_valid <= i_evt_valid;
            end
            if (o_we) begin
                r_vld[idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_evt_valid) begin
            r_s1 <= i_evt;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= fire && has;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire && has) begin
            r_out <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_out;

endmodule

// ----- design/railcom_detector_frame_decoder.sv -----
// Detector frame decoder. Takes one received byte per cycle on the slave
// stream while s_axis_tready is high and delivers at most one report per
// closed frame on the master stream. A closed frame waits in the evaluation
// stage while the output register holds a report. Its report passes the
// stage-one register and then the output register before it shows on
// m_axis_tvalid. The per-detector address table sits in a synchronous RAM.
// The RAM is read when the closing byte of an address frame for a known
// detector is taken and written when the frame leaves the evaluation stage.
// Per-entry valid bits stand for the cleared state after reset, so no
// clearing pass is needed. s_axis_tready drops only while a report is held
// in the output register and another closed frame waits behind it.
module railcom_detector_frame_decoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] detector, [22:8] loco_address, [23] forward, [24] occupied,
    // [32:25] cv_value, [40:33] command_byte, [47:41] zero
    output logic [47:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser    // [1:0] report_kind
);

    logic                      accept;
    logic                      evt_valid;
    rcd_pkg::t_frame           evt;
    logic                      rd_en;
    logic [14:0]               rd_data;
    logic                      we;
    logic [rcd_pkg::DET_W-1:0] waddr;
    logic [14:0]               wdata;
    rcd_pkg::t_result          result;

    assign accept = s_axis_tvalid && s_axis_tready;

    rcd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_byte      (s_axis_tdata),
        .o_evt_valid (evt_valid),
        .o_evt       (evt)
    );

    // Table read for address frames of a known detector
    assign rd_en = evt_valid && (evt.kind == rcd_pkg::KIND_ADDR)
                   && rcd_pkg::det_in_range(evt.det);

    rcd_ram #(
        .WIDTH (15),
        .DEPTH (rcd_pkg::TBL_DEPTH),
        .AW    (rcd_pkg::DET_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (rd_en),
        .i_raddr (evt.det[rcd_pkg::DET_W-1:0]),
        .o_rdata (rd_data)
    );

    rcd_eval u_eval (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt_valid (evt_valid),
        .i_evt       (evt),
        .i_rd_data   (rd_data),
        .o_ready     (s_axis_tready),
        .o_we        (we),
        .o_waddr     (waddr),
        .o_wdata     (wdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_result    (result)
    );

    assign m_axis_tdata = {7'd0, result.cmd, result.cv, result.occ, result.fwd,
                           result.loco, result.det};
    assign m_axis_tuser = result.kind;

endmodule

// ----- design/rcd_checker.sv -----
`include "railcom_detector_frame_decoder_assert.svh"

// Port-level checks on the decoder's report stream
module rcd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    logic        is_sys, is_cv, is_addr;
    logic        stall;
    logic [49:0] rpt;
    logic        sys_ok, cv_ok, addr_ok;

    assign is_sys  = m_axis_tvalid && (m_axis_tuser == rcd_pkg::KIND_SYS);
    assign is_cv   = m_axis_tvalid && (m_axis_tuser == rcd_pkg::KIND_CV);
    assign is_addr = m_axis_tvalid && (m_axis_tuser == rcd_pkg::KIND_ADDR);
    assign stall   = m_axis_tvalid && !m_axis_tready;
    assign rpt     = {m_axis_tuser, m_axis_tdata};

    // System report: only the reinit command
    assign sys_ok = (m_axis_tdata[32:0] == 33'd0)
                    && (m_axis_tdata[40:33] == rcd_pkg::CMD_REINIT)
                    && (m_axis_tdata[47:41] == 7'd0);

    // CV report: no address, flags or command
    assign cv_ok = (m_axis_tdata[24:8] == 17'd0) && (m_axis_tdata[47:33] == 15'd0);

    // Address report: known detector, and a nonzero address means occupied
    assign addr_ok = (m_axis_tdata[7:0] != 8'd0)
                     && (m_axis_tdata[7:0] <= 8'(rcd_pkg::DETECTORS))
                     && ((m_axis_tdata[22:8] == 15'd0) || m_axis_tdata[24]);

    // A held report does not change
    `RCD_ASSERT_NEXT(a_hold, stall, m_axis_tvalid && $stable(rpt), "held report changed")

    `RCD_ASSERT_IMPLY(a_sys, is_sys, sys_ok, "bad system report")

    `RCD_ASSERT_IMPLY(a_cv, is_cv, cv_ok, "bad CV report")

    `RCD_ASSERT_IMPLY(a_addr, is_addr, addr_ok, "bad address report")

endmodule

bind railcom_detector_frame_decoder rcd_checker u_rcd_checker (.*);
